>>> rtl/ffpa_pkg.sv
`timescale 1ns / 1ps
package ffpa_pkg;

    localparam int SIZE_W     = 23;
    localparam int ADDR_W     = 10;
    localparam int STAT_W     = 2;
    localparam int START_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int NEED_W     = 12;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_MASK  = (1 << PAGE_SHIFT) - 1;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_RUN     = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic              func;
        logic [NEED_W-1:0] need;
        logic [ADDR_W-1:0] addr;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

endpackage

>>> rtl/ffpa_ifs.sv
`timescale 1ns / 1ps
interface ffpa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [ffpa_pkg::SIZE_W-1:0]  size_bytes;
    logic [ffpa_pkg::ADDR_W-1:0]  page_address;

    modport source (output valid, func, size_bytes, page_address, input ready);
    modport sink   (input valid, func, size_bytes, page_address, output ready);
endinterface

interface ffpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ffpa_pkg::STAT_W-1:0]  status;
    logic [ffpa_pkg::START_W-1:0] start_page;
    logic [ffpa_pkg::COUNT_W-1:0] page_count;

    modport source (output valid, status, start_page, page_count, input ready);
    modport sink   (input valid, status, start_page, page_count, output ready);
endinterface

>>> rtl/ffpa_ram.sv
`timescale 1ns / 1ps
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/ffpa_front.sv
`timescale 1ns / 1ps
module ffpa_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ffpa_req_if.sink        i_req,
    output ffpa_pkg::t_qhead o_head,
    input  logic            i_pop
);
    import ffpa_pkg::*;

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic [SIZE_W:0] w_sum;
    t_item       w_item;
    logic        w_push;
    logic        w_pop;

    assign w_sum       = {1'b0, i_req.size_bytes} + (SIZE_W + 1)'(PAGE_MASK);
    assign w_item.func = i_req.func;
    assign w_item.need = w_sum[SIZE_W:PAGE_SHIFT];
    assign w_item.addr = i_req.page_address;

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= w_item;
                r_wp        <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

>>> rtl/ffpa_back.sv
`timescale 1ns / 1ps
module ffpa_back #(
    parameter int HEAP_PAGES  = 1024,
    parameter int MAX_RECORDS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ffpa_pkg::t_qhead i_head,
    output logic             o_pop,
    ffpa_rsp_if.source       o_rsp
);
    import ffpa_pkg::*;

    localparam int PW    = $clog2(HEAP_PAGES);
    localparam int PCW   = $clog2(HEAP_PAGES + 1);
    localparam int RIW   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int RCW   = $clog2(MAX_RECORDS + 1);
    localparam int REC_W = 1 + PW + PCW;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ASCAN, S_MARK, S_FSCAN, S_FINV, S_UNMARK, S_DONE
    } t_state;

    t_state           r_state;
    logic [PW-1:0]    r_clr;
    t_item            r_item;
    logic [PCW-1:0]   r_rd;
    logic             r_chk_vld;
    logic [PW-1:0]    r_chk;
    logic [PCW-1:0]   r_run;
    logic [PW-1:0]    r_pos;
    logic [PCW-1:0]   r_left;
    logic [PCW-1:0]   r_cnt;
    logic [PW-1:0]    r_start;
    logic [RCW-1:0]   r_rec_cnt;
    logic [RCW-1:0]   r_rrd;
    logic [RIW-1:0]   r_rchk;
    logic [RIW-1:0]   r_hit;
    t_status          r_res_st;
    logic [START_W-1:0] r_res_sp;
    logic [COUNT_W-1:0] r_res_pc;
    logic             r_out_vld;
    t_status          r_out_st;
    logic [START_W-1:0] r_out_sp;
    logic [COUNT_W-1:0] r_out_pc;

    logic             p_we;
    logic [PW-1:0]    p_addr;
    logic             p_wd;
    logic             p_rd;
    logic             q_we;
    logic [RIW-1:0]   q_addr;
    logic [REC_W-1:0] q_wd;
    logic [REC_W-1:0] q_rd;

    logic             w_slot_free;
    logic             w_a_issue;
    logic             w_a_found;
    logic             w_a_last;
    logic             w_f_issue;
    logic             w_f_hit;
    logic             w_f_last;
    logic             w_rec_v;
    logic [PW-1:0]    w_rec_start;
    logic [PCW-1:0]   w_rec_count;
    logic [PW-1:0]    w_a_start;
    logic             w_room;

    ffpa_ram #(.WIDTH(1), .DEPTH(HEAP_PAGES)) u_pages (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_addr (p_addr),
        .i_wdata(p_wd),
        .o_rdata(p_rd)
    );

    ffpa_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_records (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_addr (q_addr),
        .i_wdata(q_wd),
        .o_rdata(q_rd)
    );

    assign w_slot_free = !r_out_vld || o_rsp.ready;
    assign o_pop       = (r_state == S_IDLE) && i_head.valid;

    assign w_a_issue = (r_rd < PCW'(HEAP_PAGES)) && !w_a_found;
    assign w_a_found = r_chk_vld && !p_rd && (32'(r_run) + 32'd1 >= 32'(r_item.need));
    assign w_a_last  = r_chk_vld && (32'(r_chk) == HEAP_PAGES - 1) && !w_a_found;
    assign w_a_start = PW'(32'(r_chk) - 32'(r_run));
    assign w_room    = (32'(r_rec_cnt) < MAX_RECORDS);

    assign w_rec_v     = q_rd[REC_W-1];
    assign w_rec_start = q_rd[PCW +: PW];
    assign w_rec_count = q_rd[PCW-1:0];
    assign w_f_issue   = (r_rrd < r_rec_cnt) && !w_f_hit;
    assign w_f_hit     = r_chk_vld && w_rec_v && (32'(w_rec_start) == 32'(r_item.addr));
    assign w_f_last    = r_chk_vld && (32'(r_rchk) + 32'd1 == 32'(r_rec_cnt)) && !w_f_hit;

    always_comb begin
        p_we   = 1'b0;
        p_addr = r_rd[PW-1:0];
        p_wd   = 1'b0;
        q_we   = 1'b0;
        q_addr = r_rrd[RIW-1:0];
        q_wd   = {1'b1, w_a_start, PCW'(r_item.need)};
        case (r_state)
            S_CLEAR: begin
                p_we   = 1'b1;
                p_addr = r_clr;
            end
            S_ASCAN: begin
                q_we   = w_a_found && w_room;
                q_addr = r_rec_cnt[RIW-1:0];
            end
            S_MARK: begin
                p_we   = (r_left != '0);
                p_addr = r_pos;
                p_wd   = 1'b1;
            end
            S_FINV: begin
                q_we   = 1'b1;
                q_addr = r_hit;
                q_wd   = {1'b0, r_start, r_cnt};
            end
            S_UNMARK: begin
                p_we   = (r_left != '0);
                p_addr = r_pos;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_rec_cnt <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_rsp.ready && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == HEAP_PAGES - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_rd      <= '0;
                    r_rrd     <= '0;
                    r_run     <= '0;
                    r_chk_vld <= 1'b0;
                    r_res_sp  <= '0;
                    r_res_pc  <= '0;
                    if (i_head.valid) begin
                        r_item <= i_head.item;
                        if (i_head.item.func == FN_ALLOC) begin
                            if (32'(i_head.item.need) > HEAP_PAGES) begin
                                r_res_st <= ST_NO_RUN;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_ASCAN;
                            end
                        end else begin
                            if (r_rec_cnt == '0) begin
                                r_res_st <= ST_NOT_FOUND;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_FSCAN;
                            end
                        end
                    end
                end
                S_ASCAN: begin
                    r_chk_vld <= w_a_issue;
                    r_chk     <= r_rd[PW-1:0];
                    if (w_a_issue) begin
                        r_rd <= r_rd + 1'b1;
                    end
                    if (r_chk_vld) begin
                        r_run <= p_rd ? '0 : r_run + 1'b1;
                    end
                    if (w_a_found) begin
                        if (w_room) begin
                            r_rec_cnt <= r_rec_cnt + 1'b1;
                            r_pos     <= w_a_start;
                            r_left    <= PCW'(r_item.need);
                            r_res_st  <= ST_OK;
                            r_res_sp  <= START_W'(32'(w_a_start));
                            r_res_pc  <= COUNT_W'(32'(r_item.need));
                            r_state   <= S_MARK;
                        end else begin
                            r_res_st <= ST_TABLE_FULL;
                            r_state  <= S_DONE;
                        end
                    end else if (w_a_last) begin
                        r_res_st <= ST_NO_RUN;
                        r_state  <= S_DONE;
                    end
                end
                S_MARK, S_UNMARK: begin
                    if (r_left != '0) begin
                        r_pos  <= r_pos + 1'b1;
                        r_left <= r_left - 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_FSCAN: begin
                    r_chk_vld <= w_f_issue;
                    r_rchk    <= r_rrd[RIW-1:0];
                    if (w_f_issue) begin
                        r_rrd <= r_rrd + 1'b1;
                    end
                    if (w_f_hit) begin
                        r_hit    <= r_rchk;
                        r_start  <= w_rec_start;
                        r_cnt    <= w_rec_count;
                        r_pos    <= w_rec_start;
                        r_left   <= w_rec_count;
                        r_res_st <= ST_OK;
                        r_res_sp <= r_item.addr;
                        r_res_pc <= COUNT_W'(32'(w_rec_count));
                        r_state  <= S_FINV;
                    end else if (w_f_last) begin
                        r_res_st <= ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end
                end
                S_FINV: begin
                    r_chk_vld <= 1'b0;
                    r_state   <= S_UNMARK;
                end
                S_DONE: begin
                    r_chk_vld <= 1'b0;
                    if (w_slot_free) begin
                        r_out_vld <= 1'b1;
                        r_out_st  <= r_res_st;
                        r_out_sp  <= r_res_sp;
                        r_out_pc  <= r_res_pc;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out_st;
    assign o_rsp.start_page = r_out_sp;
    assign o_rsp.page_count = r_out_pc;
endmodule

>>> rtl/first_fit_page_run_allocator.sv
// First-fit page run allocator.
// i_req carries one word per request: func (0 allocate, 1 free), size_bytes
// for an allocate and page_address for a free. o_rsp returns one word per
// request: status, start_page and page_count, in request order.
// Requests enter a two-word queue, so up to two requests wait while the back
// end works; i_req drops ready while both queue slots are taken.
// An allocate scans the page-used memory one page a cycle from page 0, then
// marks the run one page a cycle. A free scans the record memory one record
// a cycle, then clears the run's pages one a cycle. Both scans are bound by
// the single-port memories.
// After reset the page-used memory is cleared page by page; requests
// queue up but none is served until the pass ends.
// When o_rsp stalls, the finished response holds and the next request waits
// in the back end until the output register frees up.
`timescale 1ns / 1ps
module first_fit_page_run_allocator #(
    parameter int HEAP_PAGES  = 1024,
    parameter int MAX_RECORDS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffpa_req_if.sink   i_req,
    ffpa_rsp_if.source o_rsp
);
    import ffpa_pkg::*;

    t_qhead w_head;
    logic   w_pop;

    ffpa_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .o_head (w_head),
        .i_pop  (w_pop)
    );

    ffpa_back #(
        .HEAP_PAGES (HEAP_PAGES),
        .MAX_RECORDS(MAX_RECORDS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (w_head),
        .o_pop  (w_pop),
        .o_rsp  (o_rsp)
    );

    a_pop_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty queue");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |->
        (o_rsp.start_page == '0 && o_rsp.page_count == '0))
        else $error("failed response carries nonzero fields");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("response valid after reset");
endmodule

>>> test/first_fit_page_run_allocator_checker.sv
`timescale 1ns / 1ps
module first_fit_page_run_allocator_checker #(
    parameter int HEAP_PAGES  = 1024,
    parameter int MAX_RECORDS = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ffpa_req_if      req,
    ffpa_rsp_if      rsp,
    output int       o_errors,
    output int       o_pending,
    output int       o_results
);
    import ffpa_pkg::*;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [START_W-1:0] start_page;
        logic [COUNT_W-1:0] page_count;
    } t_alloc_rsp;

    typedef struct {
        bit valid;
        int start;
        int count;
    } t_rec;

    bit         used_map [HEAP_PAGES];
    t_rec       recs [MAX_RECORDS];
    int         rec_count;
    t_alloc_rsp rsp_queue [$];

    function automatic t_alloc_rsp model_alloc(int size);
        t_alloc_rsp r;
        int need, run, start;
        bit found;
        need = (size + 4095) / 4096;
        run = 0;
        start = 0;
        found = 0;
        r.status = ST_NO_RUN;
        r.start_page = '0;
        r.page_count = '0;
        if (need <= HEAP_PAGES) begin
            for (int i = 0; i < HEAP_PAGES; i++) begin
                if (!used_map[i]) begin
                    run++;
                    if (run >= need) begin
                        start = i + 1 - run;
                        found = 1;
                        break;
                    end
                end else begin
                    run = 0;
                end
            end
        end
        if (!found) return r;
        if (rec_count >= MAX_RECORDS) begin
            r.status = ST_TABLE_FULL;
            return r;
        end
        for (int i = 0; i < need; i++) used_map[start + i] = 1;
        recs[rec_count].valid = 1;
        recs[rec_count].start = start;
        recs[rec_count].count = need;
        rec_count++;
        r.status = ST_OK;
        r.start_page = START_W'(start);
        r.page_count = COUNT_W'(need);
        return r;
    endfunction

    function automatic t_alloc_rsp model_free(int addr);
        t_alloc_rsp r;
        r.status = ST_NOT_FOUND;
        r.start_page = '0;
        r.page_count = '0;
        for (int k = 0; k < rec_count; k++) begin
            if (recs[k].valid && recs[k].start == addr) begin
                for (int i = 0; i < recs[k].count; i++)
                    if (addr + i < HEAP_PAGES) used_map[addr + i] = 0;
                recs[k].valid = 0;
                r.status = ST_OK;
                r.start_page = START_W'(addr);
                r.page_count = COUNT_W'(recs[k].count);
                return r;
            end
        end
        return r;
    endfunction

    assign o_pending = rsp_queue.size();

    always @(posedge i_clk) begin
        t_alloc_rsp e;
        if (!i_rst_n) begin
            foreach (used_map[i]) used_map[i] = 0;
            rec_count = 0;
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (req.valid && req.ready) begin
                if (req.func == FN_ALLOC)
                    rsp_queue.push_back(model_alloc(int'(req.size_bytes)));
                else rsp_queue.push_back(model_free(int'(req.page_address)));
            end
            if (rsp.valid && rsp.ready) begin
                o_results <= o_results + 1;
                if (rsp_queue.size() == 0) begin
                    $error("unexpected word: status %0d", rsp.status);
                    o_errors <= o_errors + 1;
                end else begin
                    e = rsp_queue.pop_front();
                    if (rsp.status !== e.status || rsp.start_page !== e.start_page ||
                        rsp.page_count !== e.page_count) begin
                        o_errors <= o_errors + 1;
                        if (rsp.status !== e.status)
                            $error("status expected %0d got %0d", e.status, rsp.status);
                        if (rsp.start_page !== e.start_page)
                            $error("start_page expected %0d got %0d", e.start_page,
                                   rsp.start_page);
                        if (rsp.page_count !== e.page_count)
                            $error("page_count expected %0d got %0d", e.page_count,
                                   rsp.page_count);
                    end
                end
            end
        end
    end
endmodule

>>> test/first_fit_page_run_allocator_tb.sv
`timescale 1ns / 1ps
module first_fit_page_run_allocator_tb;
    import ffpa_pkg::*;

    localparam int N_RANDOM = 520;
    localparam longint LIMIT = 6_000_000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, results;
    longint cycles;
    int   n_alloc, n_free;
    int   starts [$];

    ffpa_req_if req ();
    ffpa_rsp_if rsp ();

    first_fit_page_run_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .o_rsp(rsp)
    );

    first_fit_page_run_allocator_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .rsp(rsp),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("first_fit_page_run_allocator_tb: errors");
                $finish;
            end
        end
    end

    // response stall, drawn per word
    initial begin
        int w;
        rsp.ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            repeat (w) @(posedge i_clk);
            rsp.ready <= 1;
            @(posedge i_clk iff rsp.valid);
            rsp.ready <= 0;
        end
    end

    task automatic send_word(logic fn, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] pa);
        int w;
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (w > 0) begin
            req.valid <= 0;
            repeat (w) @(posedge i_clk);
        end
        req.valid <= 1;
        req.func <= fn;
        req.size_bytes <= sz;
        req.page_address <= pa;
        @(posedge i_clk iff req.ready);
        if (fn == FN_ALLOC) n_alloc++;
        else n_free++;
    endtask

    task automatic drain();
        req.valid <= 0;
        @(posedge i_clk iff pending == 0);
    endtask

    function automatic logic [SIZE_W-1:0] rand_size();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return SIZE_W'($urandom_range(0, 4194304));
        if (k == 1) return SIZE_W'($urandom);
        if (k == 2) return '0;
        return SIZE_W'($urandom_range(1, 16 * 4096));
    endfunction

    initial begin
        logic [ADDR_W-1:0] a;
        int idx;
        i_rst_n = 0;
        req.valid = 0;
        req.func = FN_ALLOC;
        req.size_bytes = '0;
        req.page_address = '0;
        n_alloc = 0;
        n_free = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: zero, one byte, page edges, whole heap, oversize, bad free
        send_word(FN_ALLOC, 23'd0, 10'd0);
        send_word(FN_ALLOC, 23'd1, 10'd0);
        send_word(FN_ALLOC, 23'd4096, 10'd0);
        send_word(FN_ALLOC, 23'd4097, 10'd0);
        send_word(FN_ALLOC, 23'd4194304, 10'd0);
        send_word(FN_ALLOC, 23'h7fffff, 10'd0);
        send_word(FN_FREE, 23'd0, 10'd0);
        send_word(FN_FREE, 23'd0, 10'd0);
        send_word(FN_FREE, 23'd0, 10'd1);
        send_word(FN_FREE, 23'd0, 10'd1023);
        send_word(FN_FREE, 23'd0, 10'd3);
        send_word(FN_ALLOC, 23'd4194304, 10'd0);
        send_word(FN_ALLOC, 23'd0, 10'd0);
        send_word(FN_ALLOC, 23'd4096, 10'd0);
        send_word(FN_FREE, 23'd0, 10'd0);
        send_word(FN_FREE, 23'd0, 10'd0);
        send_word(FN_ALLOC, 23'd4192256, 10'd0);
        send_word(FN_ALLOC, 23'd8192, 10'd0);
        send_word(FN_FREE, 23'd0, 10'h3ff);
        send_word(FN_FREE, 23'd0, 10'h2aa);
        drain();

        // random mix, frees mostly aimed at past starts
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                send_word(FN_ALLOC, rand_size(), ADDR_W'($urandom));
            end else begin
                if (starts.size() > 0 && $urandom_range(0, 4) != 0) begin
                    idx = $urandom_range(0, starts.size() - 1);
                    a = ADDR_W'(starts[idx]);
                end else begin
                    a = ADDR_W'($urandom);
                end
                send_word(FN_FREE, SIZE_W'($urandom), a);
            end
            if (i == N_RANDOM / 2) drain();
        end
        drain();
        repeat (2500) @(posedge i_clk);

        $display("covered %0d allocates and %0d frees, %0d response words checked",
                 n_alloc, n_free, results);
        if (errors == 0 && pending == 0)
            $display("first_fit_page_run_allocator_tb: clean");
        else
            $display("first_fit_page_run_allocator_tb: errors");
        $finish;
    end

    // remember returned starts so that frees hit live records
    always @(posedge i_clk)
        if (i_rst_n && rsp.valid && rsp.ready && rsp.status == ST_OK && starts.size() < 4096)
            starts.push_back(int'(rsp.start_page));
endmodule

>>> files.f
rtl/ffpa_pkg.sv
rtl/ffpa_ifs.sv
rtl/ffpa_ram.sv
rtl/ffpa_front.sv
rtl/ffpa_back.sv
rtl/first_fit_page_run_allocator.sv
test/first_fit_page_run_allocator_checker.sv
test/first_fit_page_run_allocator_tb.sv
